// ----- hw/rtl/cca_pkg.sv -----
// Shared types and constants for the calendar clock advance block.
package cca_pkg;

   // Item kind carried in tuser
   typedef enum logic {
      FUNC_ADVANCE = 1'b0,
      FUNC_SET     = 1'b1
   } func_type;

   // Calendar time as stored and returned
   typedef struct packed {
      logic [2:0]  weekday;
      logic [5:0]  seconds;
      logic [5:0]  minutes;
      logic [4:0]  hours;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
   } time_type;

   // One input word after unpacking
   typedef struct packed {
      logic [2:0] set_weekday;
      logic [5:0] set_seconds;
      logic [5:0] set_minutes;
      logic [4:0] set_hours;
      logic [4:0] set_day;
      logic [3:0] set_month;
      logic [7:0] set_year_offset;
      logic [6:0] add_seconds;
      func_type   func;
   } req_item_type;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   localparam logic [6:0]  MINUTE_SECS = 7'd60;
   localparam logic [5:0]  DAY_HOURS   = 6'd24;
   localparam logic [11:0] YEAR_BASE   = 12'd2000;
   localparam logic [2:0]  WEEKDAY_SAT = 3'd6;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_DEC   = 4'd12;
   localparam logic [3:0]  MONTH_JAN   = 4'd1;

   // Time after reset: Tuesday, January 2, 2018, 17:45:00
   localparam time_type TIME_RESET = '{
      weekday: 3'd2,
      seconds: 6'd0,
      minutes: 6'd45,
      hours:   5'd17,
      day:     5'd2,
      month:   4'd1,
      year:    12'd2018
   };

endpackage

// ----- hw/rtl/cca_req_stage.sv -----
// Input register: captures one request word and unpacks its fields.
module cca_req_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata, low bit up: add_seconds[6:0], set_year_offset[14:7], set_month[18:15],
   // set_day[23:19], set_hours[28:24], set_minutes[34:29], set_seconds[40:35],
   // set_weekday[43:41], zero fill[47:44]
   input  logic [cca_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: func[0]
   input  logic                             req_tuser,
   input  logic                             take_i,
   output logic                             item_valid_o,
   output cca_pkg::req_item_type            item_o
);

   logic                  valid_ff, valid_in;
   cca_pkg::req_item_type item_ff, item_in;
   logic                  load;

   // Accept a new word when empty or when the held one moves on this cycle
   assign req_tready = !valid_ff || take_i;
   assign load       = req_tvalid && req_tready;

   // Unpack fields
   always_comb begin
      item_in                 = item_ff;
      if (load) begin
         item_in.func            = cca_pkg::func_type'(req_tuser);
         item_in.add_seconds     = req_tdata[6:0];
         item_in.set_year_offset = req_tdata[14:7];
         item_in.set_month       = req_tdata[18:15];
         item_in.set_day         = req_tdata[23:19];
         item_in.set_hours       = req_tdata[28:24];
         item_in.set_minutes     = req_tdata[34:29];
         item_in.set_seconds     = req_tdata[40:35];
         item_in.set_weekday     = req_tdata[43:41];
      end
   end

   assign valid_in = load || (valid_ff && !take_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid_o = valid_ff;
   assign item_o       = item_ff;

endmodule

// ----- hw/rtl/cca_calendar.sv -----
// Calendar state and the advance or set update.
module cca_calendar (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  upd_i,
   input  cca_pkg::req_item_type item_i,
   output cca_pkg::time_type     time_next_o
);

   cca_pkg::time_type cur_ff, cur_in;
   cca_pkg::time_type adv;

   logic [22:0] y_prod;
   logic [5:0]  y_cent;
   logic [11:0] y_cent_x100;
   logic        div4, div100, div400, leap;
   logic [4:0]  dim;
   logic        valid_time;

   logic [1:0]  add_min;
   logic [6:0]  add_rem;
   logic [6:0]  sec_sum;
   logic        sec_c;
   logic [6:0]  min_sum;
   logic        min_c;
   logic [5:0]  hr_sum;
   logic        day_c;
   logic [5:0]  day_sum;
   logic        mon_c;

   // Days in a month; month must already be 1 to 12
   function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
      logic [4:0] d;
      case (m)
         4'd2:    d = lp ? 5'd29 : 5'd28;
         4'd4:    d = 5'd30;
         4'd6:    d = 5'd30;
         4'd9:    d = 5'd30;
         4'd11:   d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

   // Leap rule: divide year by 100 through a reciprocal (exact below 4096)
   assign y_prod      = 23'(cur_ff.year) * 23'd1311;
   assign y_cent      = y_prod[22:17];
   assign y_cent_x100 = {y_cent, 6'b0} + {1'b0, y_cent, 5'b0} + {4'b0, y_cent, 2'b0};
   assign div4        = (cur_ff.year[1:0] == 2'b00);
   assign div100      = (cur_ff.year == y_cent_x100);
   assign div400      = div100 && (y_cent[1:0] == 2'b00);
   assign leap        = div4 && (!div100 || div400);
   assign dim         = month_days(cur_ff.month, leap);

   // Check the stored time before an advance
   assign valid_time = ({1'b0, cur_ff.seconds} < cca_pkg::MINUTE_SECS)
                    && ({1'b0, cur_ff.minutes} < cca_pkg::MINUTE_SECS)
                    && ({1'b0, cur_ff.hours} < cca_pkg::DAY_HOURS)
                    && (cur_ff.month >= cca_pkg::MONTH_JAN)
                    && (cur_ff.month <= cca_pkg::MONTH_DEC)
                    && (cur_ff.day != 5'd0)
                    && (cur_ff.day <= dim);

   // Split the step into whole minutes and leftover seconds
   always_comb begin
      if (item_i.add_seconds >= 7'd120) begin
         add_min = 2'd2;
         add_rem = item_i.add_seconds - 7'd120;
      end else if (item_i.add_seconds >= cca_pkg::MINUTE_SECS) begin
         add_min = 2'd1;
         add_rem = item_i.add_seconds - cca_pkg::MINUTE_SECS;
      end else begin
         add_min = 2'd0;
         add_rem = item_i.add_seconds;
      end
   end

   // Carry chain through seconds, minutes, hours, day, month, year
   always_comb begin
      sec_sum = {1'b0, cur_ff.seconds} + add_rem;
      sec_c   = (sec_sum >= cca_pkg::MINUTE_SECS);
      min_sum = {1'b0, cur_ff.minutes} + {5'b0, add_min} + {6'b0, sec_c};
      min_c   = (min_sum >= cca_pkg::MINUTE_SECS);
      hr_sum  = {1'b0, cur_ff.hours} + {5'b0, min_c};
      day_c   = (hr_sum >= cca_pkg::DAY_HOURS);
      day_sum = {1'b0, cur_ff.day} + {5'b0, day_c};
      mon_c   = (day_sum > {1'b0, dim});

      adv.seconds = sec_c ? 6'(sec_sum - cca_pkg::MINUTE_SECS) : sec_sum[5:0];
      adv.minutes = min_c ? 6'(min_sum - cca_pkg::MINUTE_SECS) : min_sum[5:0];
      adv.hours   = day_c ? 5'(hr_sum - cca_pkg::DAY_HOURS) : hr_sum[4:0];

      adv.weekday = cur_ff.weekday;
      if (day_c) begin
         adv.weekday = (cur_ff.weekday < cca_pkg::WEEKDAY_SAT) ? cur_ff.weekday + 3'd1
                                                               : 3'd0;
      end

      adv.day   = mon_c ? 5'(day_sum - {1'b0, dim}) : day_sum[4:0];
      adv.month = cur_ff.month;
      adv.year  = cur_ff.year;
      if (mon_c) begin
         if (cur_ff.month == cca_pkg::MONTH_DEC) begin
            adv.month = cca_pkg::MONTH_JAN;
            adv.year  = cur_ff.year + 12'd1;
         end else begin
            adv.month = cur_ff.month + 4'd1;
         end
      end
   end

   // Select set, advance or clear
   always_comb begin
      cur_in = cur_ff;
      if (upd_i) begin
         case (item_i.func)
            cca_pkg::FUNC_SET: begin
               cur_in.year    = {4'b0, item_i.set_year_offset} + cca_pkg::YEAR_BASE;
               cur_in.month   = item_i.set_month;
               cur_in.day     = item_i.set_day;
               cur_in.hours   = item_i.set_hours;
               cur_in.minutes = item_i.set_minutes;
               cur_in.seconds = item_i.set_seconds;
               cur_in.weekday = item_i.set_weekday;
            end
            cca_pkg::FUNC_ADVANCE: begin
               cur_in = valid_time ? adv : '0;
            end
            default: begin
               cur_in = cur_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= cca_pkg::TIME_RESET;
      end else begin
         cur_ff <= cur_in;
      end
   end

   assign time_next_o = cur_in;

   // An advance always leaves the time of day in range
   a_adv_in_range: assert property (@(posedge clock) disable iff (reset)
      upd_i && (item_i.func == cca_pkg::FUNC_ADVANCE) |=>
         ({1'b0, cur_ff.seconds} < cca_pkg::MINUTE_SECS)
         && ({1'b0, cur_ff.minutes} < cca_pkg::MINUTE_SECS)
         && ({1'b0, cur_ff.hours} < cca_pkg::DAY_HOURS))
      else $error("advance left time of day out of range");

   // A set loads the year as offset from the base year
   a_set_year: assert property (@(posedge clock) disable iff (reset)
      upd_i && (item_i.func == cca_pkg::FUNC_SET) |=>
         cur_ff.year == ({4'b0, $past(item_i.set_year_offset)} + cca_pkg::YEAR_BASE))
      else $error("set did not load the year");

   // Without an update the calendar holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !upd_i |=> $stable(cur_ff))
      else $error("calendar changed without an update");

   // The weekday moves only when the hour wraps
   a_weekday_step: assert property (@(posedge clock) disable iff (reset)
      upd_i && (item_i.func == cca_pkg::FUNC_ADVANCE) && valid_time && !day_c
         |=> cur_ff.weekday == $past(cur_ff.weekday))
      else $error("weekday moved without a day rollover");

endmodule

// ----- hw/rtl/cca_rsp_stage.sv -----
// Result register: holds one response word until the sink takes it.
module cca_rsp_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load_i,
   input  cca_pkg::time_type                time_i,
   output logic                             can_take_o,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata, low bit up: year[11:0], month[15:12], day[20:16], hours[25:21],
   // minutes[31:26], seconds[37:32], weekday[40:38], zero fill[47:41]
   output logic [cca_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic              valid_ff, valid_in;
   cca_pkg::time_type time_ff, time_in;

   // Free when empty or when the held word leaves this cycle
   assign can_take_o = !valid_ff || rsp_tready;
   assign valid_in   = load_i || (valid_ff && !rsp_tready);
   assign time_in    = load_i ? time_i : time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
   end

   // Pack the word, year in the lowest bits
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'b0, time_ff.weekday, time_ff.seconds, time_ff.minutes,
                        time_ff.hours, time_ff.day, time_ff.month, time_ff.year};

endmodule

// ----- hw/rtl/calendar_clock_advance_core.sv -----
// A request word is held in the request register and, once the response register is
// free, passes through the calendar into it; the sink then takes it from there.
// Throughput: one word per cycle while the sink keeps taking words; the calendar is
// updated with each word loaded, so each word sees the time left by the one before it.
// Reset (synchronous, active high) empties both registers and loads the calendar
// with Tuesday, January 2, 2018, 17:45:00.
module calendar_clock_advance_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata, low bit up: add_seconds[6:0], set_year_offset[14:7], set_month[18:15],
   // set_day[23:19], set_hours[28:24], set_minutes[34:29], set_seconds[40:35],
   // set_weekday[43:41], zero fill[47:44]
   input  logic [cca_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: func[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata, low bit up: year[11:0], month[15:12], day[20:16], hours[25:21],
   // minutes[31:26], seconds[37:32], weekday[40:38], zero fill[47:41]
   output logic [cca_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic                  item_valid;
   cca_pkg::req_item_type item;
   logic                  rsp_free;
   logic                  upd;
   cca_pkg::time_type     time_next;

   // Move the held word through the calendar when the result register is free
   assign upd = item_valid && rsp_free;

   cca_req_stage u_req (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .take_i       (rsp_free),
      .item_valid_o (item_valid),
      .item_o       (item)
   );

   cca_calendar u_cal (
      .clock       (clock),
      .reset       (reset),
      .upd_i       (upd),
      .item_i      (item),
      .time_next_o (time_next)
   );

   cca_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load_i     (upd),
      .time_i     (time_next),
      .can_take_o (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
